### design/gbn_pkg.sv
package gbn_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_ACK     = 2'd2;

    // Frame kinds carried by a result item.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    // Highest sequence number; a count that reaches it wraps to zero.
    localparam logic [7:0] SEQ_WRAP    = 8'd255;
    localparam logic [3:0] RETRY_RESET = 4'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] ack_number;
        logic [4:0] offered_window;
    } in_item_t;

    typedef struct packed {
        logic       frame_kind;
        logic [7:0] sequence_number;
        logic       last;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pending;
        logic slot_free;
    } dp_status_t;

endpackage

### design/gbn_ctrl.sv
module gbn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gbn_pkg::dp_status_t status,
    output gbn_pkg::ctrl_cmd_t  cmd
);

    gbn_pkg::state_t state_reg;
    gbn_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gbn_pkg::ST_EMIT;
                end
            end
            gbn_pkg::ST_EMIT:
            begin
                if (!status.pending)
                begin
                    state_next = gbn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            gbn_pkg::ST_EMIT:
            begin
                // One frame goes into the output register whenever it is free.
                cmd.step = status.pending && status.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/gbn_dp.sv
module gbn_dp #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gbn_pkg::in_item_t   in_data,
    output gbn_pkg::out_item_t  out_data,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                cfg_write_en,
    input  logic [3:0]          cfg_write_data,
    input  gbn_pkg::ctrl_cmd_t  cmd,
    output gbn_pkg::dp_status_t status
);

    localparam int WW = $clog2(MAX_WINDOW + 1);

    logic [3:0]         retry_limit_reg;
    logic [7:0]         seq_reg, seq_next;
    logic [WW-1:0]      win_reg, win_next;
    logic               req_sent_reg, req_sent_next;
    logic [3:0]         retries_reg, retries_next;
    logic               pend_req_reg, pend_req_next;
    logic [WW-1:0]      remain_reg, remain_next;
    logic               out_valid_reg, out_valid_next;
    gbn_pkg::out_item_t out_data_reg, out_data_next;

    // State after the command is applied, before frames are generated.
    logic [7:0]    seq_mid;
    logic [WW-1:0] win_mid;
    logic [WW-1:0] win_clamped;
    logic          req_sent_mid;
    logic [3:0]    retries_mid;
    logic          gen;
    logic [7:0]    seq_inc;

    always_comb
    begin
        if (32'(in_data.offered_window) > MAX_WINDOW)
        begin
            win_clamped = WW'(MAX_WINDOW);
        end
        else
        begin
            win_clamped = WW'(in_data.offered_window);
        end
    end

    always_comb
    begin
        seq_mid      = seq_reg;
        win_mid      = win_reg;
        req_sent_mid = req_sent_reg;
        retries_mid  = retries_reg;
        gen          = 1'b0;
        unique case (in_data.command)
            gbn_pkg::CMD_START:
            begin
                req_sent_mid = 1'b0;
                gen          = 1'b1;
            end
            gbn_pkg::CMD_TIMEOUT:
            begin
                if (retries_reg != 4'd0)
                begin
                    retries_mid = retries_reg - 4'd1;
                    gen         = 1'b1;
                    // Step back one window, clamping at zero; at zero, ask again.
                    if (seq_reg == 8'd0)
                    begin
                        req_sent_mid = 1'b0;
                    end
                    else if (seq_reg > 8'(win_reg))
                    begin
                        seq_mid = seq_reg - 8'(win_reg);
                    end
                    else
                    begin
                        seq_mid = 8'd0;
                    end
                end
            end
            gbn_pkg::CMD_ACK:
            begin
                if (in_data.ack_number == 8'd0)
                begin
                    win_mid = win_clamped;
                end
                else if (in_data.ack_number >= gbn_pkg::SEQ_WRAP)
                begin
                    seq_mid = 8'd0;
                end
                else
                begin
                    seq_mid = in_data.ack_number;
                end
                retries_mid = retry_limit_reg;
                gen         = 1'b1;
            end
            default:
            begin
                gen = 1'b0;
            end
        endcase
    end

    assign seq_inc = seq_reg + 8'd1;

    always_comb
    begin
        seq_next       = seq_reg;
        win_next       = win_reg;
        req_sent_next  = req_sent_reg;
        retries_next   = retries_reg;
        pend_req_next  = pend_req_reg;
        remain_next    = remain_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            seq_next      = seq_mid;
            win_next      = win_mid;
            req_sent_next = req_sent_mid;
            retries_next  = retries_mid;
            if (gen)
            begin
                if (!req_sent_mid)
                begin
                    req_sent_next = 1'b1;
                    pend_req_next = 1'b1;
                    remain_next   = '0;
                end
                else
                begin
                    pend_req_next = 1'b0;
                    remain_next   = win_mid;
                end
            end
        end
        else if (cmd.step)
        begin
            out_valid_next = 1'b1;
            if (pend_req_reg)
            begin
                pend_req_next                 = 1'b0;
                out_data_next.frame_kind      = gbn_pkg::KIND_REQUEST;
                out_data_next.sequence_number = seq_reg;
                out_data_next.last            = 1'b1;
            end
            else
            begin
                remain_next                   = remain_reg - WW'(1);
                out_data_next.frame_kind      = gbn_pkg::KIND_DATA;
                out_data_next.sequence_number = seq_inc;
                out_data_next.last            = (remain_reg == WW'(1));
                seq_next = (seq_inc == gbn_pkg::SEQ_WRAP) ? 8'd0 : seq_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= gbn_pkg::RETRY_RESET;
            seq_reg         <= '0;
            win_reg         <= '0;
            req_sent_reg    <= 1'b0;
            retries_reg     <= gbn_pkg::RETRY_RESET;
            pend_req_reg    <= 1'b0;
            remain_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                retry_limit_reg <= cfg_write_data;
            end
            seq_reg       <= seq_next;
            win_reg       <= win_next;
            req_sent_reg  <= req_sent_next;
            retries_reg   <= retries_next;
            pend_req_reg  <= pend_req_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_data         = out_data_reg;
    assign out_valid        = out_valid_reg;
    assign status.pending   = pend_req_reg || (remain_reg != '0);
    assign status.slot_free = !out_valid_reg || out_ready;

endmodule

### design/go_back_n_sender_top.sv
// Go-Back-N sender. Each input transfer is a start, a timeout tick or an
// acknowledgement, and causes either one window request, a window of up to
// MAX_WINDOW data frames (sequence numbers 1..255, wrapping), or nothing;
// the last flag marks the final frame of each input. The block takes one
// input per cycle in which it is idle, then emits its frames one by one,
// each once the output register is free, and takes no new input until
// it is idle again. The last frame may still sit in the output register
// while the next input is taken. retry_limit (reset 3) is written
// through cfg_write_en/cfg_write_data; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module go_back_n_sender_top #(
    parameter int MAX_WINDOW = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gbn_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output gbn_pkg::out_item_t out_data,
    input  logic               cfg_write_en,
    input  logic [3:0]         cfg_write_data
);

    gbn_pkg::ctrl_cmd_t  cmd;
    gbn_pkg::dp_status_t status;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    gbn_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_data        (in_data),
        .out_data       (out_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

### test/gbn_frame_checker.sv
`timescale 1ns / 100ps

module gbn_frame_checker #(
    parameter int MAX_WINDOW = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  gbn_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  gbn_pkg::out_item_t out_data,
    input  logic               cfg_write_en,
    input  logic [3:0]         cfg_write_data,
    output int                 fail_count,
    output int                 pending_count
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the sender's registers.
    logic [3:0] retry_limit;
    logic [7:0] shadow_seq;
    logic [4:0] shadow_win;
    logic       req_sent;
    logic [3:0] retries;

    gbn_pkg::out_item_t expected_frames[$];

    task automatic push_frame(input logic kind, input logic [7:0] seq, input logic is_last);
        gbn_pkg::out_item_t f;
        f.frame_kind      = kind;
        f.sequence_number = seq;
        f.last            = is_last;
        expected_frames.push_back(f);
    endtask

    // Either one window request or a full window of data frames.
    task automatic send_frames();
        int count;
        if (!req_sent)
        begin
            req_sent = 1'b1;
            push_frame(gbn_pkg::KIND_REQUEST, shadow_seq, 1'b1);
        end
        else
        begin
            count = (shadow_win > MAX_WINDOW) ? MAX_WINDOW : int'(shadow_win);
            for (int i = 0; i < count; i++)
            begin
                shadow_seq = shadow_seq + 8'd1;
                push_frame(gbn_pkg::KIND_DATA, shadow_seq, i == count - 1);
                if (shadow_seq >= gbn_pkg::SEQ_WRAP)
                    shadow_seq = '0;
            end
        end
    endtask

    task automatic predict_event(input gbn_pkg::in_item_t item);
        unique case (item.command)
            gbn_pkg::CMD_START:
            begin
                req_sent = 1'b0;
                send_frames();
            end
            gbn_pkg::CMD_TIMEOUT:
            begin
                if (retries != 4'd0)
                begin
                    retries = retries - 4'd1;
                    // Step back one window; a count at zero asks for the window again.
                    if (shadow_seq == 8'd0)
                        req_sent = 1'b0;
                    else if (shadow_seq > 8'(shadow_win))
                        shadow_seq = shadow_seq - 8'(shadow_win);
                    else
                        shadow_seq = '0;
                    send_frames();
                end
            end
            gbn_pkg::CMD_ACK:
            begin
                if (item.ack_number == 8'd0)
                    shadow_win = (item.offered_window > MAX_WINDOW) ? 5'(MAX_WINDOW)
                                                                    : item.offered_window;
                else
                    shadow_seq = (item.ack_number >= gbn_pkg::SEQ_WRAP) ? 8'd0
                                                                         : item.ack_number;
                retries = retry_limit;
                send_frames();
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gbn_pkg::out_item_t want;
        if (!rst_n)
        begin
            retry_limit   = gbn_pkg::RETRY_RESET;
            shadow_seq    = '0;
            shadow_win    = '0;
            req_sent      = 1'b0;
            retries       = gbn_pkg::RETRY_RESET;
            expected_frames.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            // Results are compared before the new input is predicted, since a
            // frame leaving at this edge always belongs to an earlier input.
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected frame: expected none, got kind %0d seq %0d last %0d",
                                 out_data.frame_kind, out_data.sequence_number,
                                 out_data.last);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (out_data.frame_kind !== want.frame_kind
                        || out_data.sequence_number !== want.sequence_number
                        || out_data.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("frame mismatch (kind/seq/last): exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.frame_kind, want.sequence_number, want.last,
                                     out_data.frame_kind, out_data.sequence_number,
                                     out_data.last);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_event(in_data);
            if (cfg_write_en)
                retry_limit = cfg_write_data;
            pending_count = expected_frames.size();
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int MAX_WINDOW      = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = MAX_WINDOW + 4;

    // Command code 3 is not assigned; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    gbn_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    gbn_pkg::out_item_t out_data;
    logic               cfg_write_en;
    logic [3:0]         cfg_write_data;

    int fail_count;
    int pending_count;
    int items_sent;
    int quiet_cycles;
    bit hold_off_req;
    bit no_idle;

    go_back_n_sender_top #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    gbn_frame_checker #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_event(input logic [1:0] cmd, input logic [7:0] ack,
                              input logic [4:0] win);
        gbn_pkg::in_item_t item;
        int                g;
        item.command        = cmd;
        item.ack_number     = ack;
        item.offered_window = win;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            g = gap_len();
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // Wait until every predicted frame has been seen, then let an input that
    // causes no frames finish inside the block.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_retry_limit(input logic [3:0] value);
        drain();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    function automatic logic [4:0] pick_window();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return 5'($urandom_range(1, 4));
        if (roll == 7)
            return 5'd0;
        if (roll == 8)
            return 5'($urandom_range(5, 16));
        return 5'($urandom_range(17, 31));
    endfunction

    function automatic logic [7:0] pick_ack();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'd255;
        if (roll == 1)
            return 8'd254;
        if (roll == 2)
            return 8'd1;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic random_event();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            send_event(gbn_pkg::CMD_START, 8'($urandom), 5'($urandom));
        else if (roll < 12)
            send_event(CMD_UNUSED, 8'($urandom), 5'($urandom));
        else if (roll < 40)
            send_event(gbn_pkg::CMD_TIMEOUT, 8'($urandom), 5'($urandom));
        else if (roll < 44)
            // A run of timeouts, at its longest enough to use up even the largest retry limit.
            repeat ($urandom_range(4, 18))
                send_event(gbn_pkg::CMD_TIMEOUT, 8'($urandom), 5'($urandom));
        else if (roll < 62)
            send_event(gbn_pkg::CMD_ACK, 8'd0, pick_window());
        else
            send_event(gbn_pkg::CMD_ACK, pick_ack(), 5'($urandom));
    endtask

    task automatic random_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            random_event();
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        int g;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                out_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // The run is ended when no transfer happens for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        hold_off_req   = 1'b0;
        no_idle        = 1'b0;
        items_sent     = 0;
        rst_n          = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with the reset retry limit of three.
        send_event(gbn_pkg::CMD_START, 8'hFF, 5'h1F);
        send_event(gbn_pkg::CMD_ACK, 8'h00, 5'd0);
        send_event(gbn_pkg::CMD_TIMEOUT, 8'h00, 5'd0);
        send_event(gbn_pkg::CMD_ACK, 8'h00, 5'd31);
        send_event(gbn_pkg::CMD_TIMEOUT, 8'hFF, 5'h1F);
        send_event(gbn_pkg::CMD_ACK, 8'd250, 5'd0);
        send_event(gbn_pkg::CMD_TIMEOUT, 8'd0, 5'd0);
        send_event(gbn_pkg::CMD_ACK, 8'd255, 5'd0);
        send_event(gbn_pkg::CMD_ACK, 8'h00, 5'd17);
        send_event(gbn_pkg::CMD_ACK, 8'h00, 5'd1);
        send_event(gbn_pkg::CMD_ACK, 8'd200, 5'd0);
        send_event(gbn_pkg::CMD_TIMEOUT, 8'd0, 5'd0);
        send_event(gbn_pkg::CMD_ACK, 8'd254, 5'd0);
        send_event(gbn_pkg::CMD_ACK, 8'h00, 5'd16);
        send_event(gbn_pkg::CMD_ACK, 8'd128, 5'd0);
        send_event(CMD_UNUSED, 8'hFF, 5'h1F);
        repeat (5)
            send_event(gbn_pkg::CMD_TIMEOUT, 8'd0, 5'd0);
        send_event(gbn_pkg::CMD_ACK, 8'd1, 5'd0);
        send_event(gbn_pkg::CMD_START, 8'h00, 5'd0);
        send_event(gbn_pkg::CMD_ACK, 8'h00, 5'd2);
        send_event(gbn_pkg::CMD_ACK, 8'd127, 5'd0);

        write_retry_limit(4'd0);
        random_phase(60);

        // The highest retry limit, with no idling on either side.
        write_retry_limit(4'd15);
        no_idle = 1'b1;
        random_phase(60);

        // Long receiver hold-off while the sender keeps offering full windows.
        hold_off_req = 1'b1;
        send_event(gbn_pkg::CMD_ACK, 8'h00, 5'd16);
        repeat (30)
            send_event(gbn_pkg::CMD_ACK, pick_ack(), 5'($urandom));
        no_idle = 1'b0;
        drain();

        write_retry_limit(4'($urandom_range(1, 14)));
        random_phase(80);
        write_retry_limit(4'd3);
        random_phase(80);
        write_retry_limit(4'($urandom_range(0, 15)));
        random_phase(30);

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
design/gbn_pkg.sv
design/gbn_ctrl.sv
design/gbn_dp.sv
design/go_back_n_sender_top.sv
test/gbn_frame_checker.sv
test/tb.sv
